/* design/indexed_shift_list_defines.svh */
// Assertion macros used by the indexed shift list top level.
`ifndef INDEXED_SHIFT_LIST_DEFINES_SVH
`define INDEXED_SHIFT_LIST_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check that prop holds at every clock edge outside reset.
`define ISL_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("indexed_shift_list: check failed");

// Check that cond is never true outside reset.
`define ISL_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("indexed_shift_list: forbidden condition seen");

`else

`define ISL_ASSERT(label, clk, rst_n, prop)
`define ISL_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

/* design/isl_pkg.sv */
// Shared types, request codes and status codes for the indexed shift list.
`timescale 1ns / 1ps

package isl_pkg;

  // Default list capacity
  localparam int ISL_CAPACITY = 16;

  // Width of the insert anchor index; covers capacities up to 256
  localparam int ISL_AT_W = 8;

  // Request codes
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_APPEND     = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_INSERT_AT  = 3'd4;
  localparam logic [2:0] REQ_LAST       = 3'd5;
  localparam logic [2:0] REQ_SEARCH     = 3'd6;
  localparam logic [2:0] REQ_STATUS     = 3'd7;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // Request transaction payload
  typedef struct packed {
    logic [2:0]         req_type;
    logic [4:0]         position;
    logic signed [31:0] item_value;
  } isl_req_t;

  // Result transaction payload
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic               found;
    logic [4:0]         entry_count;
    logic               is_empty;
    logic               is_full;
  } isl_rsp_t;

  // Shift command broadcast along the cell chain
  typedef struct packed {
    logic                ins;  // open a gap at 'at' and load the new word there
    logic                del;  // every cell takes its upper neighbour's word
    logic [ISL_AT_W-1:0] at;
  } isl_shift_t;

endpackage

/* design/isl_cell.sv */
// One storage cell of the list chain: holds a word, shifts, compares and selects.
`timescale 1ns / 1ps

module isl_cell
  import isl_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic               clk,
  input  isl_shift_t         shift,
  input  logic signed [31:0] prev_data,   // word of the cell below
  input  logic signed [31:0] next_data,   // word of the cell above
  input  logic signed [31:0] load_data,
  input  logic signed [31:0] key,
  input  logic               live,        // cell lies below the count
  input  logic               pick,        // cell is the last live entry
  output logic signed [31:0] data,
  output logic               hit,
  output logic signed [31:0] picked
);

  localparam logic [ISL_AT_W-1:0] MyIdx = ISL_AT_W'(INDEX);

  logic signed [31:0] data_r;
  logic signed [31:0] data_nxt;

  // Choose hold, shift up, shift down or load
  always_comb begin
    data_nxt = data_r;
    if (shift.ins) begin
      if (MyIdx == shift.at) begin
        data_nxt = load_data;
      end else if (MyIdx > shift.at) begin
        data_nxt = prev_data;
      end
    end else if (shift.del) begin
      data_nxt = next_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // Compare against the search key and gate the word for the tail read
  assign data   = data_r;
  assign hit    = live && (data_r == key);
  assign picked = pick ? data_r : 32'sd0;

endmodule

/* design/indexed_shift_list.sv */
// Top level of the indexed shift list: request decode, cell chain and result stages.
//
//   Channel | Ports                         | Payload
//   --------+-------------------------------+-----------
//   request | in_valid, in_ready, in_data   | isl_req_t
//   result  | out_valid, out_ready, out_data| isl_rsp_t
//
// Each request passes two register stages: the cells shift and the count
// updates at acceptance, then the search match and tail word are gathered
// from the cells into the output register when the middle stage moves on.
// One request is taken per cycle while the result side keeps up. A stalled
// output holds the middle stage, and then in_ready drops. Reset empties the
// list.
`timescale 1ns / 1ps

`include "indexed_shift_list_defines.svh"

module indexed_shift_list
  import isl_pkg::*;
#(
  parameter int CAPACITY = ISL_CAPACITY
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  isl_req_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output isl_rsp_t out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
  localparam logic [CNT_W-1:0] CntFull = CNT_W'(CAPACITY);

  // Control state
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload held between stages
  logic               pend_search_r;
  logic               pend_last_r;
  logic signed [31:0] pend_key_r;
  logic [1:0]         pend_status_r;
  isl_rsp_t           out_data_r;

  logic       in_fire;
  logic       pend_move;
  logic       is_full_now;
  logic       is_empty_now;
  logic [1:0] status_nxt;
  logic       search_nxt;
  logic       last_nxt;
  isl_shift_t shift_dec;
  isl_shift_t shift;

  logic signed [31:0] cell_data   [CAPACITY];
  logic signed [31:0] cell_picked [CAPACITY];
  logic [CAPACITY-1:0] cell_hit;
  logic [CAPACITY-1:0] cell_live;
  logic [CAPACITY-1:0] cell_pick;
  logic signed [31:0] tail_word;
  isl_rsp_t           rsp_nxt;

  // Handshake: accept while the middle stage is free or moving on
  assign pend_move = pend_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !pend_valid_r || pend_move;
  assign in_fire   = in_valid && in_ready;

  assign is_full_now  = (count_r == CntFull);
  assign is_empty_now = (count_r == '0);

  // Decode the request against the current count
  always_comb begin
    status_nxt   = ST_OK;
    count_nxt    = count_r;
    search_nxt   = 1'b0;
    last_nxt     = 1'b0;
    shift_dec    = '0;
    case (in_data.req_type)
      REQ_PUSH_FRONT: begin
        if (is_full_now) begin
          status_nxt = ST_FULL;
        end else begin
          shift_dec.ins = 1'b1;
          shift_dec.at  = '0;
          count_nxt     = CNT_W'(count_r + 1'b1);
        end
      end
      REQ_APPEND: begin
        if (is_full_now) begin
          status_nxt = ST_FULL;
        end else begin
          shift_dec.ins = 1'b1;
          shift_dec.at  = ISL_AT_W'(count_r);
          count_nxt     = CNT_W'(count_r + 1'b1);
        end
      end
      REQ_POP_FRONT: begin
        if (is_empty_now) begin
          status_nxt = ST_EMPTY;
        end else begin
          shift_dec.del = 1'b1;
          count_nxt     = CNT_W'(count_r - 1'b1);
        end
      end
      REQ_POP_BACK: begin
        if (is_empty_now) begin
          status_nxt = ST_EMPTY;
        end else begin
          count_nxt = CNT_W'(count_r - 1'b1);
        end
      end
      REQ_INSERT_AT: begin
        if (is_full_now) begin
          status_nxt = ST_FULL;
        end else if (CMP_W'(in_data.position) > CMP_W'(count_r)) begin
          status_nxt = ST_RANGE;
        end else begin
          shift_dec.ins = 1'b1;
          shift_dec.at  = ISL_AT_W'(in_data.position);
          count_nxt     = CNT_W'(count_r + 1'b1);
        end
      end
      REQ_LAST: begin
        if (is_empty_now) begin
          status_nxt = ST_EMPTY;
        end else begin
          last_nxt = 1'b1;
        end
      end
      REQ_SEARCH: begin
        search_nxt = 1'b1;
      end
      REQ_STATUS: begin
        status_nxt = ST_OK;
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // Only an accepted transaction moves the chain
  assign shift = in_fire ? shift_dec : '0;

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] prev_word;
    logic signed [31:0] next_word;

    if (i == 0) begin : g_first
      assign prev_word = in_data.item_value;
    end else begin : g_mid
      assign prev_word = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_top
      assign next_word = cell_data[i];
    end else begin : g_below
      assign next_word = cell_data[i+1];
    end

    assign cell_live[i] = (CNT_W'(i) < count_r);
    assign cell_pick[i] = (CNT_W'(i + 1) == count_r);

    isl_cell #(
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .shift     (shift),
      .prev_data (prev_word),
      .next_data (next_word),
      .load_data (in_data.item_value),
      .key       (pend_key_r),
      .live      (cell_live[i]),
      .pick      (cell_pick[i]),
      .data      (cell_data[i]),
      .hit       (cell_hit[i]),
      .picked    (cell_picked[i])
    );
  end

  // Gather the tail word from the selected cell
  always_comb begin
    tail_word = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      tail_word = tail_word | cell_picked[k];
    end
  end

  // Form the result from the middle stage and the cells
  always_comb begin
    rsp_nxt             = '0;
    rsp_nxt.status      = pend_status_r;
    rsp_nxt.read_value  = pend_last_r ? tail_word : 32'sd0;
    rsp_nxt.found       = pend_search_r && (|cell_hit);
    rsp_nxt.entry_count = 5'(count_r);
    rsp_nxt.is_empty    = is_empty_now;
    rsp_nxt.is_full     = is_full_now;
  end

  // Advance valid flags
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    if (in_fire) begin
      pend_valid_nxt = 1'b1;
    end else if (pend_move) begin
      pend_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (pend_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r <= count_nxt;
      end
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_search_r <= search_nxt;
      pend_last_r   <= last_nxt;
      pend_key_r    <= in_data.item_value;
      pend_status_r <= status_nxt;
    end
    if (pend_move) begin
      out_data_r <= rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks on the count and the stage hand-off
  `ISL_ASSERT(a_count_bound, clk, rst_n, count_r <= CntFull)
  `ISL_ASSERT(a_count_still, clk, rst_n, !in_fire |=> $stable(count_r))
  `ISL_ASSERT_NEVER(a_flags_clash, clk, rst_n, out_valid_r && out_data_r.is_empty && out_data_r.is_full)
  `ISL_ASSERT(a_pend_kept, clk, rst_n, (pend_valid_r && !pend_move) |=> pend_valid_r)

endmodule

/* test/testbench.sv */
// Self-checking testbench for the indexed shift list: random and directed requests with checks.
`timescale 1ns / 1ps

module testbench;
  import isl_pkg::*;

  localparam int LIST_DEPTH = ISL_CAPACITY;

  typedef struct {
    bit       pause;  // hold the sender until every result is back
    isl_req_t req;
  } pending_item_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  isl_req_t in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  isl_rsp_t out_data;

  indexed_shift_list #(.CAPACITY(LIST_DEPTH)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Shadow copy of the list contents and length
  logic signed [31:0] shadow_words [LIST_DEPTH];
  int unsigned        shadow_count = 0;

  pending_item_t pending_requests[$];
  isl_rsp_t      awaited_results[$];

  int unsigned sent_count = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count = 0;
  int unsigned hold_cycles = 0;
  bit          hold_done = 1'b0;

  // Stimulus-side bookkeeping: expected length and recently stored values
  int unsigned        plan_count = 0;
  logic signed [31:0] value_pool [8];
  int unsigned        pool_next = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the shadow list and build the result it gives
  function automatic isl_rsp_t apply_list_request(isl_req_t rq);
    isl_rsp_t rsp;
    int       k;
    rsp = '0;
    rsp.status = ST_OK;
    case (rq.req_type)
      REQ_PUSH_FRONT: begin
        if (shadow_count >= LIST_DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          for (k = shadow_count; k > 0; k--) shadow_words[k] = shadow_words[k-1];
          shadow_words[0] = rq.item_value;
          shadow_count++;
        end
      end
      REQ_APPEND: begin
        if (shadow_count >= LIST_DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          shadow_words[shadow_count] = rq.item_value;
          shadow_count++;
        end
      end
      REQ_POP_FRONT: begin
        if (shadow_count == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          for (k = 0; k + 1 < shadow_count; k++) shadow_words[k] = shadow_words[k+1];
          shadow_count--;
        end
      end
      REQ_POP_BACK: begin
        if (shadow_count == 0) rsp.status = ST_EMPTY;
        else shadow_count--;
      end
      REQ_INSERT_AT: begin
        if (shadow_count >= LIST_DEPTH) begin
          rsp.status = ST_FULL;
        end else if (rq.position > shadow_count) begin
          rsp.status = ST_RANGE;
        end else begin
          for (k = shadow_count; k > rq.position; k--) shadow_words[k] = shadow_words[k-1];
          shadow_words[rq.position] = rq.item_value;
          shadow_count++;
        end
      end
      REQ_LAST: begin
        if (shadow_count == 0) rsp.status = ST_EMPTY;
        else rsp.read_value = shadow_words[shadow_count-1];
      end
      REQ_SEARCH: begin
        for (k = 0; k < shadow_count; k++)
          if (shadow_words[k] == rq.item_value) rsp.found = 1'b1;
      end
      default: begin
      end
    endcase
    rsp.entry_count = shadow_count[4:0];
    rsp.is_empty = (shadow_count == 0);
    rsp.is_full = (shadow_count == LIST_DEPTH);
    return rsp;
  endfunction

  // Queue one request and track the list length it leaves behind
  task automatic queue_request(logic [2:0] op, logic [4:0] pos, logic signed [31:0] val);
    pending_item_t item;
    item.pause = 1'b0;
    item.req.req_type = op;
    item.req.position = pos;
    item.req.item_value = val;
    pending_requests.push_back(item);
    case (op)
      REQ_PUSH_FRONT, REQ_APPEND: begin
        if (plan_count < LIST_DEPTH) plan_count++;
      end
      REQ_INSERT_AT: begin
        if (plan_count < LIST_DEPTH && pos <= plan_count) plan_count++;
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (plan_count > 0) plan_count--;
      end
      default: begin
      end
    endcase
    if (op == REQ_PUSH_FRONT || op == REQ_APPEND || op == REQ_INSERT_AT) begin
      value_pool[pool_next] = val;
      pool_next = (pool_next + 1) % 8;
    end
  endtask

  function automatic logic signed [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return value_pool[3'($urandom_range(7))];
    if (r < 20) begin
      case ($urandom_range(3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh0000_0000;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  // Mode 0 grows the list, mode 1 shrinks it, mode 2 mixes evenly
  function automatic logic [2:0] pick_op(int unsigned mode);
    int unsigned r;
    r = $urandom_range(99);
    if (mode == 2) return 3'($urandom_range(7));
    if (r < 60) begin
      if (mode == 0) begin
        case ($urandom_range(2))
          0: return REQ_PUSH_FRONT;
          1: return REQ_APPEND;
          default: return REQ_INSERT_AT;
        endcase
      end
      return ($urandom_range(1) == 0) ? REQ_POP_FRONT : REQ_POP_BACK;
    end
    if (r < 75) begin
      if (mode == 0) return ($urandom_range(1) == 0) ? REQ_POP_FRONT : REQ_POP_BACK;
      return ($urandom_range(1) == 0) ? REQ_APPEND : REQ_INSERT_AT;
    end
    case ($urandom_range(2))
      0: return REQ_LAST;
      1: return REQ_SEARCH;
      default: return REQ_STATUS;
    endcase
  endfunction

  task automatic report_mismatch(string field_name, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field_name, want, got);
    fail_count++;
  endtask

  // Driver: record accepted transactions and present the next pending request
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_results.push_back(apply_list_request(in_data));
        sent_count++;
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() > 0 && pending_requests[0].pause) begin
          if (awaited_results.size() == 0 && !(in_valid && in_ready))
            void'(pending_requests.pop_front());
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0 &&
                     ((sent_count >= 300 && sent_count < 380) ||
                      $urandom_range(99) >= 19)) begin
          in_valid <= 1'b1;
          in_data <= pending_requests[0].req;
          void'(pending_requests.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          fail_count++;
        end else begin
          if (out_data.status !== awaited_results[0].status)
            report_mismatch("status", awaited_results[0].status, out_data.status);
          if (out_data.read_value !== awaited_results[0].read_value)
            report_mismatch("read_value", awaited_results[0].read_value, out_data.read_value);
          if (out_data.found !== awaited_results[0].found)
            report_mismatch("found", awaited_results[0].found, out_data.found);
          if (out_data.entry_count !== awaited_results[0].entry_count)
            report_mismatch("entry_count", awaited_results[0].entry_count,
                            out_data.entry_count);
          if (out_data.is_empty !== awaited_results[0].is_empty)
            report_mismatch("is_empty", awaited_results[0].is_empty, out_data.is_empty);
          if (out_data.is_full !== awaited_results[0].is_full)
            report_mismatch("is_full", awaited_results[0].is_full, out_data.is_full);
          void'(awaited_results.pop_front());
        end
      end
      // Hold off once for a long stretch so the block backs up
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else if (!hold_done && results_seen >= 120) begin
        hold_done = 1'b1;
        hold_cycles = 60;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (results_seen >= 300 && results_seen < 380) ||
                     ($urandom_range(99) >= 19);
      end
    end
  end

  initial begin
    pending_item_t   pause_item;
    int unsigned     mode;
    logic [2:0]      op;
    logic [4:0]      pos;
    for (int i = 0; i < 8; i++) value_pool[i] = 32'sd0;
    mode = 0;

    // Directed: empty list, extreme values, range errors, middle insert
    queue_request(REQ_STATUS, 5'd0, 32'sd0);
    queue_request(REQ_POP_FRONT, 5'd0, 32'sd0);
    queue_request(REQ_POP_BACK, 5'd31, 32'sd0);
    queue_request(REQ_LAST, 5'd0, 32'sd0);
    queue_request(REQ_SEARCH, 5'd0, 32'sd0);
    queue_request(REQ_INSERT_AT, 5'd1, 32'sd5);
    queue_request(REQ_INSERT_AT, 5'd31, -32'sd1);
    queue_request(REQ_INSERT_AT, 5'd0, 32'sh8000_0000);
    queue_request(REQ_PUSH_FRONT, 5'd0, 32'sh7fff_ffff);
    queue_request(REQ_APPEND, 5'd0, -32'sd1);
    queue_request(REQ_LAST, 5'd0, 32'sd0);
    queue_request(REQ_SEARCH, 5'd0, 32'sh8000_0000);
    queue_request(REQ_SEARCH, 5'd0, 32'sd0);
    queue_request(REQ_INSERT_AT, 5'd3, 32'sh5555_5555);
    queue_request(REQ_INSERT_AT, 5'd1, 32'shAAAA_AAAA);
    queue_request(REQ_INSERT_AT, 5'd6, 32'sd7);
    queue_request(REQ_LAST, 5'd0, 32'sd0);
    queue_request(REQ_POP_FRONT, 5'd0, 32'sd0);
    queue_request(REQ_POP_BACK, 5'd0, 32'sd0);
    queue_request(REQ_SEARCH, 5'd0, 32'shAAAA_AAAA);
    queue_request(REQ_STATUS, 5'd31, -32'sd1);
    queue_request(REQ_POP_FRONT, 5'd0, 32'sd0);
    queue_request(REQ_POP_BACK, 5'd0, 32'sd0);
    queue_request(REQ_POP_FRONT, 5'd0, 32'sd0);
    queue_request(REQ_POP_BACK, 5'd0, 32'sd0);

    // Random: phases that fill, drain or mix, with one full pause midway
    for (int i = 0; i < 425; i++) begin
      if (i % 40 == 0) mode = $urandom_range(2);
      if (i == 225) begin
        pause_item.pause = 1'b1;
        pause_item.req = '0;
        pending_requests.push_back(pause_item);
      end
      op = pick_op(mode);
      if (op == REQ_INSERT_AT && $urandom_range(99) < 80) pos = 5'($urandom_range(plan_count, 0));
      else pos = 5'($urandom_range(31));
      if (op == REQ_SEARCH && $urandom_range(1) == 0)
        queue_request(op, pos, value_pool[3'($urandom_range(7))]);
      else
        queue_request(op, pos, pick_value());
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all requests sent, all results back, then a short settle
    while (pending_requests.size() != 0 || in_valid) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/isl_pkg.sv
design/isl_cell.sv
design/indexed_shift_list.sv
test/testbench.sv
